FILE: rtl/sccbm_pkg.sv
// Shared types and codes for the SCCB master transaction sequencer.
// Used by sccbm_seq and sccb_master_transaction; depends on nothing.
`default_nettype none

package sccbm_pkg;

    // Input op codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_START    = 2'd1;
    localparam logic [1:0] STATUS_NO_ACK   = 2'd2;

    localparam logic [7:0] DEV_ADDR_RESET = 8'd66;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_START      = 4'd1,
        ST_TX_DEV     = 4'd2,
        ST_ACK_DEV    = 4'd3,
        ST_TX_REG     = 4'd4,
        ST_ACK_REG    = 4'd5,
        ST_TX_DATA    = 4'd6,
        ST_ACK_DATA   = 4'd7,
        ST_STOP_MID   = 4'd8,
        ST_START2     = 4'd9,
        ST_TX_DEVR    = 4'd10,
        ST_ACK_DEVR   = 4'd11,
        ST_RX         = 4'd12,
        ST_ACKOUT     = 4'd13,
        ST_STOP_END   = 4'd14,
        ST_STOP_ABORT = 4'd15
    } step_t;

    typedef struct packed {
        step_t      step;
        logic [1:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic [7:0] bytes_left;
        logic       is_read;
        logic [7:0] reg_addr;
        logic [7:0] wdata;
        logic       scl;
        logic       sda;
    } seq_state_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy;
        logic       byte_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       done;
        logic [1:0] status;
    } seq_result_t;

endpackage

`default_nettype wire

FILE: rtl/sccbm_seq.sv
// Next-state and result logic for one bus delay slot of the SCCB sequencer.
// Combinational only; uses sccbm_pkg types and codes.
`default_nettype none

module sccbm_seq (
    input  var sccbm_pkg::seq_state_t  cur,
    input  wire logic [1:0]            op,
    input  wire logic                  sda_in,
    input  wire logic [7:0]            dev_addr,
    output sccbm_pkg::seq_state_t      nxt,
    output sccbm_pkg::seq_result_t     res
);

    sccbm_pkg::seq_state_t st;
    logic                  bv;
    logic [7:0]            rb;
    logic                  lb;
    logic                  done;
    logic [1:0]            status;
    logic [3:0]            bit_inc;
    logic [7:0]            rx_shift;
    logic [7:0]            left_dec;

    assign bit_inc  = cur.bit_cnt + 4'd1;
    assign left_dec = (cur.bytes_left != 8'd0) ? cur.bytes_left - 8'd1 : 8'd0;

    always_comb begin
        st       = cur;
        bv       = 1'b0;
        rb       = 8'd0;
        lb       = 1'b0;
        done     = 1'b0;
        status   = sccbm_pkg::STATUS_OK;
        rx_shift = {cur.shift[6:0], sda_in};

        // a command starts only from idle; this slot is already start phase 0
        if (cur.step == sccbm_pkg::ST_IDLE &&
            (op == sccbm_pkg::OP_WRITE || op == sccbm_pkg::OP_READ)) begin
            st.reg_addr   = 8'd0;
            st.reg_addr   = cur.reg_addr;
            st.is_read    = (op == sccbm_pkg::OP_READ);
            st.shift      = 8'd0;
            st.step       = sccbm_pkg::ST_START;
            st.phase      = 2'd0;
            st.bit_cnt    = 4'd0;
        end

        nxt = st;
        unique case (st.step)
            sccbm_pkg::ST_IDLE: begin
            end
            sccbm_pkg::ST_START, sccbm_pkg::ST_START2: begin
                if (st.phase == 2'd0) begin
                    nxt.scl = 1'b1;
                    nxt.sda = 1'b1;
                    if (!sda_in) begin
                        done   = 1'b1;
                        status = sccbm_pkg::STATUS_START;
                        nxt.step = sccbm_pkg::ST_IDLE;
                        nxt.phase = 2'd0;
                        nxt.bit_cnt = 4'd0;
                    end else begin
                        nxt.phase = 2'd1;
                    end
                end else if (st.phase == 2'd1) begin
                    nxt.sda = 1'b0;
                    if (sda_in) begin
                        done   = 1'b1;
                        status = sccbm_pkg::STATUS_START;
                        nxt.step = sccbm_pkg::ST_IDLE;
                        nxt.phase = 2'd0;
                        nxt.bit_cnt = 4'd0;
                    end else begin
                        nxt.phase = 2'd2;
                    end
                end else begin
                    nxt.sda     = 1'b0;
                    nxt.phase   = 2'd0;
                    nxt.bit_cnt = 4'd0;
                    if (st.step == sccbm_pkg::ST_START) begin
                        nxt.step  = sccbm_pkg::ST_TX_DEV;
                        nxt.shift = dev_addr;
                    end else begin
                        nxt.step  = sccbm_pkg::ST_TX_DEVR;
                        nxt.shift = dev_addr + 8'd1;
                    end
                end
            end
            sccbm_pkg::ST_TX_DEV, sccbm_pkg::ST_TX_REG,
            sccbm_pkg::ST_TX_DATA, sccbm_pkg::ST_TX_DEVR: begin
                if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = 2'd1;
                end else if (st.phase == 2'd1) begin
                    nxt.sda   = st.shift[7];
                    nxt.phase = 2'd2;
                end else begin
                    nxt.scl     = 1'b1;
                    nxt.shift   = {st.shift[6:0], 1'b0};
                    nxt.bit_cnt = bit_inc;
                    nxt.phase   = 2'd0;
                    if (bit_inc >= sccbm_pkg::BITS_PER_BYTE) begin
                        // each transmit step is followed by its ack step
                        nxt.step    = sccbm_pkg::step_t'(st.step + 4'd1);
                        nxt.bit_cnt = 4'd0;
                    end
                end
            end
            sccbm_pkg::ST_ACK_DEV, sccbm_pkg::ST_ACK_REG,
            sccbm_pkg::ST_ACK_DATA, sccbm_pkg::ST_ACK_DEVR: begin
                if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = 2'd1;
                end else if (st.phase == 2'd1) begin
                    nxt.sda   = 1'b1;
                    nxt.phase = 2'd2;
                end else begin
                    nxt.scl     = 1'b1;
                    nxt.phase   = 2'd0;
                    nxt.bit_cnt = 4'd0;
                    priority if (st.step == sccbm_pkg::ST_ACK_DEV) begin
                        if (sda_in) begin
                            nxt.step = sccbm_pkg::ST_STOP_ABORT;
                        end else begin
                            nxt.step  = sccbm_pkg::ST_TX_REG;
                            nxt.shift = st.reg_addr;
                        end
                    end else if (st.step == sccbm_pkg::ST_ACK_REG) begin
                        if (st.is_read) begin
                            nxt.step = sccbm_pkg::ST_STOP_MID;
                        end else begin
                            nxt.step  = sccbm_pkg::ST_TX_DATA;
                            nxt.shift = st.wdata;
                        end
                    end else if (st.step == sccbm_pkg::ST_ACK_DATA) begin
                        nxt.step = sccbm_pkg::ST_STOP_END;
                    end else begin
                        if (sda_in) begin
                            nxt.step = sccbm_pkg::ST_STOP_ABORT;
                        end else if (st.bytes_left == 8'd0) begin
                            nxt.step = sccbm_pkg::ST_STOP_END;
                        end else begin
                            nxt.step  = sccbm_pkg::ST_RX;
                            nxt.shift = 8'd0;
                        end
                    end
                end
            end
            sccbm_pkg::ST_RX: begin
                if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b0;
                    nxt.sda   = 1'b1;
                    nxt.phase = 2'd1;
                end else begin
                    nxt.scl     = 1'b1;
                    nxt.shift   = rx_shift;
                    nxt.bit_cnt = bit_inc;
                    nxt.phase   = 2'd0;
                    if (bit_inc >= sccbm_pkg::BITS_PER_BYTE) begin
                        bv          = 1'b1;
                        rb          = rx_shift;
                        lb          = (st.bytes_left == 8'd1);
                        nxt.step    = sccbm_pkg::ST_ACKOUT;
                        nxt.bit_cnt = 4'd0;
                    end
                end
            end
            sccbm_pkg::ST_ACKOUT: begin
                if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = 2'd1;
                end else if (st.phase == 2'd1) begin
                    // no-ack on the last byte
                    nxt.sda   = (st.bytes_left <= 8'd1);
                    nxt.phase = 2'd2;
                end else if (st.phase == 2'd2) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd3;
                end else begin
                    nxt.scl        = 1'b0;
                    nxt.bytes_left = left_dec;
                    nxt.phase      = 2'd0;
                    nxt.bit_cnt    = 4'd0;
                    if (left_dec == 8'd0) begin
                        nxt.step = sccbm_pkg::ST_STOP_END;
                    end else begin
                        nxt.step  = sccbm_pkg::ST_RX;
                        nxt.shift = 8'd0;
                    end
                end
            end
            sccbm_pkg::ST_STOP_MID, sccbm_pkg::ST_STOP_END,
            sccbm_pkg::ST_STOP_ABORT: begin
                if (st.phase == 2'd0) begin
                    nxt.scl   = 1'b0;
                    nxt.phase = 2'd1;
                end else if (st.phase == 2'd1) begin
                    nxt.sda   = 1'b0;
                    nxt.phase = 2'd2;
                end else if (st.phase == 2'd2) begin
                    nxt.scl   = 1'b1;
                    nxt.phase = 2'd3;
                end else begin
                    nxt.sda     = 1'b1;
                    nxt.phase   = 2'd0;
                    nxt.bit_cnt = 4'd0;
                    if (st.step == sccbm_pkg::ST_STOP_MID) begin
                        nxt.step = sccbm_pkg::ST_START2;
                    end else begin
                        done     = 1'b1;
                        status   = (st.step == sccbm_pkg::ST_STOP_ABORT) ?
                                   sccbm_pkg::STATUS_NO_ACK : sccbm_pkg::STATUS_OK;
                        nxt.step = sccbm_pkg::ST_IDLE;
                    end
                end
            end
        endcase

        res.scl_out    = nxt.scl;
        res.sda_out    = nxt.sda;
        res.busy       = (nxt.step != sccbm_pkg::ST_IDLE);
        res.byte_valid = bv;
        res.read_byte  = rb;
        res.last_byte  = lb;
        res.done       = done;
        res.status     = status;
    end

endmodule

`default_nettype wire

FILE: rtl/sccb_master_transaction.sv
// Top level of the SCCB master transaction sequencer: stream ports, state and
// result registers. Depends on sccbm_pkg and sccbm_seq.
`default_nettype none

// Each accepted input transaction is one bus delay slot and yields exactly one
// result transaction in the following cycle. A new slot is accepted every cycle
// while the result register is empty or being drained, so the sustained rate is
// one slot per clock; it is set by the combinational sequencer update between
// the state registers and the result register. op 1 starts a register write and
// op 2 a register read, only when no transaction is running; the slot that
// takes the command is the first slot of the start condition. The device write
// address is set through the cfg port (reset 66) and should be written while
// no transaction is running.
module sccb_master_transaction (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,      // device_write_address
    // input slots
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,       // reg_addr, write_data, read_length, sda_in
    input  wire logic [1:0]  s_tuser,       // op
    // results
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,       // scl_out, sda_out, busy_res, read_byte,
                                            // done_res, status
    output      logic        m_tuser,       // byte_valid
    output      logic        m_tlast        // last_byte
);

    sccbm_pkg::seq_state_t  state_reg;
    sccbm_pkg::seq_state_t  cur;
    sccbm_pkg::seq_state_t  state_next;
    sccbm_pkg::seq_result_t res_next;
    logic [7:0]             dev_addr_reg;
    logic                   m_tvalid_reg;
    logic [15:0]            m_tdata_reg;
    logic                   m_tuser_reg;
    logic                   m_tlast_reg;
    logic                   s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    // command operands enter through the held fields when the sequencer is idle
    always_comb begin
        cur = state_reg;
        if (state_reg.step == sccbm_pkg::ST_IDLE) begin
            cur.reg_addr   = s_tdata[7:0];
            cur.wdata      = s_tdata[15:8];
            cur.bytes_left = s_tdata[23:16];
        end
    end

    sccbm_seq u_seq (
        .cur      (cur),
        .op       (s_tuser),
        .sda_in   (s_tdata[24]),
        .dev_addr (dev_addr_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '{step: sccbm_pkg::ST_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
            dev_addr_reg <= sccbm_pkg::DEV_ADDR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                dev_addr_reg <= cfg_data;
            end
            if (s_accept) begin
                // held fields are reloaded by every command, so idle slots may overwrite them
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {2'b00, res_next.status, res_next.done, res_next.read_byte,
                            res_next.busy, res_next.sda_out, res_next.scl_out};
            m_tuser_reg <= res_next.byte_valid;
            m_tlast_reg <= res_next.last_byte;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // a finished transaction reports not busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |-> !m_tdata[2])
        else $error("done result still reports busy");

    // received bytes only arrive while a read is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[2] && state_reg.is_read))
        else $error("read byte outside a read transaction");

    // status is only reported with done
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[13:12] != sccbm_pkg::STATUS_OK)) |-> m_tdata[11])
        else $error("status without done");

    // idle sequencer stays idle without an accepted slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.step == sccbm_pkg::ST_IDLE && !s_accept) |=>
        (state_reg.step == sccbm_pkg::ST_IDLE))
        else $error("sequencer left idle without a slot");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for sccb_master_transaction: models the SDA line per slot, predicts
// every result transaction and checks it field by field under random stalls on both sides.
// Depends on sccbm_pkg and the RTL of sccb_master_transaction.

module tb;
    import sccbm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // How the simulated bus answers on SDA
    typedef enum {
        BUS_CLEAN, BUS_SOMETIMES, BUS_NOISE, BUS_BUSY, BUS_ERR, BUS_NACK_DEV, BUS_NACK_DEVR
    } bus_mode_t;

    class slot_scoreboard;
        logic [7:0]  dev_addr;
        step_t       step;
        logic [1:0]  phase;
        logic [3:0]  nbits;
        logic [7:0]  shreg;
        logic [7:0]  left;
        logic [7:0]  held_reg;
        logic [7:0]  held_data;
        logic        rd;
        logic        scl;
        logic        sda;
        seq_result_t expected_lines[$];
        int errors, checked, slots, commands, bytes_read;
        int ends_ok, ends_start, ends_nack, addr_settings;

        function new();
            dev_addr = DEV_ADDR_RESET;
            step = ST_IDLE;
            phase = '0;
            nbits = '0;
            shreg = '0;
            left = '0;
            held_reg = '0;
            held_data = '0;
            rd = 1'b0;
            scl = 1'b1;
            sda = 1'b1;
            addr_settings = 1;
        endfunction

        function void enter_step(step_t s);
            step = s;
            phase = '0;
            nbits = '0;
        endfunction

        function void note_slot(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                                logic [7:0] rl, logic sda_in);
            seq_result_t r;
            r = '0;
            slots++;
            if (step == ST_IDLE && (op == OP_WRITE || op == OP_READ)) begin
                held_reg = ra;
                held_data = wd;
                left = rl;
                rd = (op == OP_READ);
                shreg = '0;
                commands++;
                enter_step(ST_START);
            end
            case (step)
                ST_IDLE: ;
                ST_START, ST_START2: begin
                    if (phase == 2'd0) begin
                        scl = 1'b1;
                        sda = 1'b1;
                        if (!sda_in) begin
                            r.done = 1'b1;
                            r.status = STATUS_START;
                            ends_start++;
                            enter_step(ST_IDLE);
                        end else begin
                            phase = 2'd1;
                        end
                    end else if (phase == 2'd1) begin
                        sda = 1'b0;
                        if (sda_in) begin
                            r.done = 1'b1;
                            r.status = STATUS_START;
                            ends_start++;
                            enter_step(ST_IDLE);
                        end else begin
                            phase = 2'd2;
                        end
                    end else begin
                        sda = 1'b0;
                        // read address wraps at 8 bits
                        shreg = (step == ST_START) ? dev_addr : dev_addr + 8'd1;
                        enter_step(step == ST_START ? ST_TX_DEV : ST_TX_DEVR);
                    end
                end
                ST_TX_DEV, ST_TX_REG, ST_TX_DATA, ST_TX_DEVR: begin
                    if (phase == 2'd0) begin
                        scl = 1'b0;
                        phase = 2'd1;
                    end else if (phase == 2'd1) begin
                        sda = shreg[7];
                        phase = 2'd2;
                    end else begin
                        scl = 1'b1;
                        shreg = shreg << 1;
                        nbits++;
                        phase = 2'd0;
                        if (nbits >= BITS_PER_BYTE) enter_step(step_t'(step + 1));
                    end
                end
                ST_ACK_DEV, ST_ACK_REG, ST_ACK_DATA, ST_ACK_DEVR: begin
                    if (phase == 2'd0) begin
                        scl = 1'b0;
                        phase = 2'd1;
                    end else if (phase == 2'd1) begin
                        sda = 1'b1;
                        phase = 2'd2;
                    end else begin
                        scl = 1'b1;
                        case (step)
                            ST_ACK_DEV: begin
                                if (sda_in) begin
                                    enter_step(ST_STOP_ABORT);
                                end else begin
                                    shreg = held_reg;
                                    enter_step(ST_TX_REG);
                                end
                            end
                            ST_ACK_REG: begin
                                if (rd) begin
                                    enter_step(ST_STOP_MID);
                                end else begin
                                    shreg = held_data;
                                    enter_step(ST_TX_DATA);
                                end
                            end
                            ST_ACK_DATA: enter_step(ST_STOP_END);
                            default: begin
                                if (sda_in) begin
                                    enter_step(ST_STOP_ABORT);
                                end else if (left == 8'd0) begin
                                    enter_step(ST_STOP_END);
                                end else begin
                                    enter_step(ST_RX);
                                    shreg = '0;
                                end
                            end
                        endcase
                    end
                end
                ST_RX: begin
                    if (phase == 2'd0) begin
                        scl = 1'b0;
                        sda = 1'b1;
                        phase = 2'd1;
                    end else begin
                        scl = 1'b1;
                        shreg = {shreg[6:0], sda_in};
                        nbits++;
                        phase = 2'd0;
                        if (nbits >= BITS_PER_BYTE) begin
                            r.byte_valid = 1'b1;
                            r.read_byte = shreg;
                            r.last_byte = (left == 8'd1);
                            bytes_read++;
                            enter_step(ST_ACKOUT);
                        end
                    end
                end
                ST_ACKOUT: begin
                    if (phase == 2'd0) begin
                        scl = 1'b0;
                        phase = 2'd1;
                    end else if (phase == 2'd1) begin
                        // no-ack on the last byte
                        sda = (left <= 8'd1);
                        phase = 2'd2;
                    end else if (phase == 2'd2) begin
                        scl = 1'b1;
                        phase = 2'd3;
                    end else begin
                        scl = 1'b0;
                        if (left > 8'd0) left--;
                        if (left == 8'd0) begin
                            enter_step(ST_STOP_END);
                        end else begin
                            enter_step(ST_RX);
                            shreg = '0;
                        end
                    end
                end
                ST_STOP_MID, ST_STOP_END, ST_STOP_ABORT: begin
                    if (phase == 2'd0) begin
                        scl = 1'b0;
                        phase = 2'd1;
                    end else if (phase == 2'd1) begin
                        sda = 1'b0;
                        phase = 2'd2;
                    end else if (phase == 2'd2) begin
                        scl = 1'b1;
                        phase = 2'd3;
                    end else begin
                        sda = 1'b1;
                        if (step == ST_STOP_MID) begin
                            enter_step(ST_START2);
                        end else begin
                            r.done = 1'b1;
                            if (step == ST_STOP_ABORT) begin
                                r.status = STATUS_NO_ACK;
                                ends_nack++;
                            end else begin
                                r.status = STATUS_OK;
                                ends_ok++;
                            end
                            enter_step(ST_IDLE);
                        end
                    end
                end
            endcase
            r.scl_out = scl;
            r.sda_out = sda;
            r.busy = (step != ST_IDLE);
            expected_lines.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("ERROR: %s", msg);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, expected %0h",
                                 checked, name, got, want));
        endtask

        task check_result(logic [15:0] data, logic user, logic last);
            seq_result_t w;
            if (expected_lines.size() == 0) begin
                report("result transaction with nothing expected");
                return;
            end
            w = expected_lines.pop_front();
            checked++;
            compare_field("scl_out", data[0], w.scl_out);
            compare_field("sda_out", data[1], w.sda_out);
            compare_field("busy", data[2], w.busy);
            compare_field("read_byte", data[10:3], w.read_byte);
            compare_field("done", data[11], w.done);
            compare_field("status", data[13:12], w.status);
            compare_field("pad", data[15:14], 8'd0);
            compare_field("byte_valid", user, w.byte_valid);
            compare_field("last_byte", last, w.last_byte);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // reg_addr, write_data, read_length, sda_in
    logic [1:0]  s_tuser;      // op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // scl_out, sda_out, busy_res, read_byte, done_res, status
    logic        m_tuser;      // byte_valid
    logic        m_tlast;      // last_byte

    slot_scoreboard sb = new;
    int src_burst = 0;
    int snk_burst = 0;

    sccb_master_transaction u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Mostly random waits, with occasional long stretches of back-to-back transactions
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            burst = $urandom_range(30, 150);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    // SDA level the bus presents in the next slot, given the predicted sequencer state
    function automatic logic line_sda(logic [1:0] op, bus_mode_t mode);
        logic       fresh;
        step_t      s;
        logic [1:0] ph;
        bit         slip;
        fresh = (sb.step == ST_IDLE) && (op == OP_WRITE || op == OP_READ);
        s = fresh ? ST_START : sb.step;
        ph = fresh ? 2'd0 : sb.phase;
        slip = (mode == BUS_SOMETIMES) && ($urandom_range(0, 39) == 0);
        if (mode == BUS_NOISE) return 1'($urandom_range(0, 1));
        case (s)
            ST_START, ST_START2: begin
                if (ph == 2'd0) return !(slip || mode == BUS_BUSY);
                if (ph == 2'd1) return slip || mode == BUS_ERR;
            end
            ST_ACK_DEV: if (ph == 2'd2) return slip || mode == BUS_NACK_DEV;
            ST_ACK_DEVR: if (ph == 2'd2) return slip || mode == BUS_NACK_DEVR;
            default: ;
        endcase
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_slot(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                             input logic [7:0] rl, input bus_mode_t mode);
        int   gap;
        logic sda_in;
        gap = draw_wait(src_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        sda_in = line_sda(op, mode);
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, sda_in, rl, wd, ra};
        s_tuser <= op;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_slot(op, ra, wd, rl, sda_in);
    endtask

    // One command slot, then slots with random content until the sequencer is idle again
    task automatic run_txn(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                           input logic [7:0] rl, input bus_mode_t mode);
        send_slot(op, ra, wd, rl, mode);
        while (sb.step != ST_IDLE)
            send_slot(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom), mode);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (sb.expected_lines.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        while (sb.step != ST_IDLE)
            send_slot(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), BUS_SOMETIMES);
        wait_results();
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_dev_addr(input logic [7:0] addr);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.dev_addr = addr;
        sb.addr_settings++;
    endtask

    task automatic random_phase(input int count);
        int         stop_at;
        int         pick;
        logic [1:0] op;
        logic [7:0] rl;
        bus_mode_t  mode;
        stop_at = sb.slots + count;
        while (sb.slots < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                op = $urandom_range(0, 1) ? OP_TICK : OP_UNUSED;
                send_slot(op, 8'($urandom), 8'($urandom), 8'($urandom), BUS_NOISE);
            end else begin
                op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                // long reads are slow, keep most of them short
                rl = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(4, 12)) :
                                                    8'($urandom_range(0, 3));
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    mode = BUS_SOMETIMES;
                else if (pick < 15)
                    mode = BUS_NOISE;
                else
                    mode = bus_mode_t'($urandom_range(BUS_BUSY, BUS_NACK_DEVR));
                run_txn(op, 8'($urandom), 8'($urandom), rl, mode);
            end
            if ($urandom_range(0, 29) == 0) wait_results();
        end
    endtask

    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_wait(snk_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready));
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        logic [7:0] addrs[4];
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_TICK;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed cases at the reset device address
        send_slot(OP_TICK, 8'h00, 8'h00, 8'h00, BUS_CLEAN);
        send_slot(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, BUS_CLEAN);
        run_txn(OP_WRITE, 8'h00, 8'hFF, 8'h00, BUS_CLEAN);
        run_txn(OP_WRITE, 8'hFF, 8'h00, 8'hFF, BUS_CLEAN);
        run_txn(OP_READ, 8'h5A, 8'h00, 8'h00, BUS_CLEAN);
        run_txn(OP_READ, 8'hA5, 8'h00, 8'h01, BUS_CLEAN);
        run_txn(OP_READ, 8'h3C, 8'h00, 8'h02, BUS_CLEAN);
        run_txn(OP_WRITE, 8'h12, 8'h34, 8'h00, BUS_BUSY);
        run_txn(OP_READ, 8'h12, 8'h34, 8'h01, BUS_ERR);
        run_txn(OP_WRITE, 8'h56, 8'h78, 8'h00, BUS_NACK_DEV);
        run_txn(OP_READ, 8'h9A, 8'hBC, 8'h03, BUS_NACK_DEVR);
        run_txn(OP_READ, 8'h80, 8'h7F, 8'h04, BUS_CLEAN);
        send_slot(OP_TICK, 8'h00, 8'h00, 8'h00, BUS_CLEAN);

        // top address: the read address wraps to zero
        settle();
        write_dev_addr(8'hFF);
        run_txn(OP_READ, 8'h01, 8'h00, 8'h02, BUS_CLEAN);
        run_txn(OP_WRITE, 8'hFE, 8'h01, 8'h00, BUS_CLEAN);

        addrs[0] = 8'h00;
        addrs[1] = 8'($urandom);
        addrs[2] = 8'($urandom);
        addrs[3] = DEV_ADDR_RESET;
        foreach (addrs[i]) begin
            settle();
            write_dev_addr(addrs[i]);
            random_phase(30);
        end

        wait_results();
        repeat (10) @(posedge aclk);
        $display("Covered %0d bus slots, %0d commands over %0d device addresses, %0d bytes read",
                 sb.slots, sb.commands, sb.addr_settings, sb.bytes_read);
        $display("Endings: %0d ok, %0d failed start, %0d unacked address; %0d results checked",
                 sb.ends_ok, sb.ends_start, sb.ends_nack, sb.checked);
        if (sb.errors == 0 && sb.expected_lines.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", sb.expected_lines.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
